// ===== rtl/core/skset_pkg.sv =====
// Shared types and constants for the sorted key set core.
// No dependencies; every other file in rtl/core uses it by scoped name.
`default_nettype none

package skset_pkg;

	localparam int CAPACITY = 1024;
	localparam int KEY_BITS = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// Hit reduction: cells are ORed in groups, then the groups are ORed.
	localparam int GRP_SZ  = 2 ** (($clog2(CAPACITY) + 1) / 2);
	localparam int GRP_CNT = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

	typedef enum logic [1:0] {
		REQ_MEMBER = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2
	} req_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GROUP,
		ST_FOLD,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [KEY_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic             success;
		logic             full_reject;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	// Broadcast shift commands for the cell row.
	typedef struct packed {
		logic ins;
		logic del;
	} shift_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/skset_cell.sv =====
// One cell of the sorted key row: holds a key, compares, shifts with neighbors.
// Depends on skset_pkg.
`default_nettype none

module skset_cell (
	input  wire logic                           clk,
	input  wire logic                           cmp_en,
	input  wire logic [skset_pkg::KEY_BITS-1:0] bcast_key,
	input  wire logic                           occupied,
	input  wire skset_pkg::shift_ctrl_t         ctrl,
	input  wire logic [skset_pkg::KEY_BITS-1:0] prev_key,
	input  wire logic                           prev_lt,
	input  wire logic [skset_pkg::KEY_BITS-1:0] next_key,
	output logic      [skset_pkg::KEY_BITS-1:0] key_out,
	output logic                                lt_out,
	output logic                                eq_out
);

	logic [skset_pkg::KEY_BITS-1:0] key_q;
	logic                           lt_q;
	logic                           eq_q;

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			lt_q <= occupied && (key_q < bcast_key);
			eq_q <= occupied && (key_q == bcast_key);
		end
		// Cells below the insertion point hold; the rest move one place.
		if (ctrl.ins && !lt_q) begin
			key_q <= prev_lt ? bcast_key : prev_key;
		end else if (ctrl.del && !lt_q) begin
			key_q <= next_key;
		end
	end

	assign key_out = key_q;
	assign lt_out  = lt_q;
	assign eq_out  = eq_q;

endmodule

`default_nettype wire

// ===== rtl/core/skset_hit_tree.sv =====
// Two-stage registered OR of the per-cell match flags.
// Depends on skset_pkg.
`default_nettype none

module skset_hit_tree (
	input  wire logic                           clk,
	input  wire logic [skset_pkg::CAPACITY-1:0] eq,
	output logic                                hit
);

	localparam int PAD_W = skset_pkg::GRP_CNT * skset_pkg::GRP_SZ;

	logic [PAD_W-1:0]                  eq_pad;
	logic [skset_pkg::GRP_CNT-1:0]     grp_s1;
	logic                              hit_s2;

	assign eq_pad = PAD_W'(eq);

	always_ff @(posedge clk) begin
		for (int g = 0; g < skset_pkg::GRP_CNT; g++) begin
			grp_s1[g] <= |eq_pad[g*skset_pkg::GRP_SZ +: skset_pkg::GRP_SZ];
		end
		hit_s2 <= |grp_s1;
	end

	assign hit = hit_s2;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_key_set_core.sv =====
// Top level of the sorted key set: sequencer, cell row, hit reduction, result register.
// Depends on skset_pkg, skset_cell and skset_hit_tree.
//
// Usage:
//   A request beat on req (req_valid/req_ready) carries an operation (member,
//   insert, delete) and a key. Each request yields exactly one response beat
//   on rsp (rsp_valid/rsp_ready) with success, full_reject and the key count
//   after the request. Request type 3 changes nothing and reports the count.
//   Keys sit in a row of cells in ascending order; every cell compares its key
//   with the request key in parallel, and inserts/deletes shift the row by one
//   place, each cell taking its neighbor's key.
// Sequence:
//   A request is compared as it is accepted, then passes the group and fold
//   steps of the registered OR of the match flags and an apply step that
//   shifts the row. The response is valid the cycle after apply. A new request
//   is taken only once the previous one has been applied; requests do not overlap.
// Reset:
//   arst_n clears the key count, the sequencer and the response valid; the
//   set is empty after reset. Cell contents are not cleared.
// Backpressure:
//   The response register holds its beat until taken. The block accepts the
//   next request while a response waits, and stalls in the apply cycle only
//   if an older response is still not taken.
`default_nettype none

module sorted_key_set_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire skset_pkg::req_t   req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output skset_pkg::rsp_t        rsp
);

	localparam int N = skset_pkg::CAPACITY;

	// Sequencer state and latched request.
	skset_pkg::state_t               state_q;
	skset_pkg::state_t               state_nxt;
	skset_pkg::req_op_t              op_q;
	logic [skset_pkg::KEY_BITS-1:0]  key_q;
	logic [skset_pkg::CNT_W-1:0]     count_q;

	// Response register.
	logic                            rsp_valid_q;
	skset_pkg::rsp_t                 rsp_q;

	// Decoded controls.
	logic                            accept;
	logic                            apply_go;
	logic                            hit;
	logic                            is_full;
	logic                            do_ins;
	logic                            do_del;
	logic                            ok;
	logic                            full_flag;
	skset_pkg::shift_ctrl_t          ctrl;
	logic [skset_pkg::KEY_BITS-1:0]  bcast_key;

	// Cell row wiring.
	logic [skset_pkg::KEY_BITS-1:0]  cell_key [N];
	logic [N-1:0]                    cell_lt;
	logic [N-1:0]                    cell_eq;

	assign accept  = req_valid && req_ready;
	assign is_full = (count_q == skset_pkg::CNT_W'(N));

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			skset_pkg::ST_IDLE:  begin
				if (accept) state_nxt = skset_pkg::ST_GROUP;
			end
			skset_pkg::ST_GROUP: state_nxt = skset_pkg::ST_FOLD;
			skset_pkg::ST_FOLD:  state_nxt = skset_pkg::ST_APPLY;
			skset_pkg::ST_APPLY: begin
				if (!rsp_valid_q || rsp_ready) state_nxt = skset_pkg::ST_IDLE;
			end
			default:             state_nxt = skset_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req_ready = 1'b0;
		apply_go  = 1'b0;
		case (state_q)
			skset_pkg::ST_IDLE:  req_ready = 1'b1;
			skset_pkg::ST_APPLY: apply_go  = !rsp_valid_q || rsp_ready;
			default: begin
				req_ready = 1'b0;
				apply_go  = 1'b0;
			end
		endcase
	end

	// Decide the outcome from the reduced hit flag.
	always_comb begin
		do_ins    = 1'b0;
		do_del    = 1'b0;
		ok        = 1'b0;
		full_flag = 1'b0;
		case (op_q)
			skset_pkg::REQ_MEMBER: ok = hit;
			skset_pkg::REQ_INSERT: begin
				// Presence wins over the full check.
				if (!hit) begin
					full_flag = is_full;
					do_ins    = !is_full;
					ok        = !is_full;
				end
			end
			skset_pkg::REQ_DELETE: begin
				do_del = hit;
				ok     = hit;
			end
			default: ok = 1'b0;
		endcase
	end

	assign ctrl.ins  = apply_go && do_ins;
	assign ctrl.del  = apply_go && do_del;
	// Compare against the incoming key; insert the latched one.
	assign bcast_key = (state_q == skset_pkg::ST_IDLE) ? req.key : key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skset_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.ins) begin
				count_q <= count_q + skset_pkg::CNT_W'(1);
			end else if (ctrl.del) begin
				count_q <= count_q - skset_pkg::CNT_W'(1);
			end
			// Drop the held beat when taken; load the new one on apply.
			if (apply_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= skset_pkg::req_op_t'(req.req_type);
			key_q <= req.key;
		end
		if (apply_go) begin
			rsp_q.success     <= ok;
			rsp_q.full_reject <= full_flag;
			// Count after this request.
			if (ctrl.ins) begin
				rsp_q.entry_count <= count_q + skset_pkg::CNT_W'(1);
			end else if (ctrl.del) begin
				rsp_q.entry_count <= count_q - skset_pkg::CNT_W'(1);
			end else begin
				rsp_q.entry_count <= count_q;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Row of cells, each talking to its two neighbors.
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [skset_pkg::KEY_BITS-1:0] prev_key;
		logic                           prev_lt;
		logic [skset_pkg::KEY_BITS-1:0] next_key;
		logic                           occupied;

		if (i == 0) begin : g_first
			assign prev_key = cell_key[i];
			assign prev_lt  = 1'b1;
		end else begin : g_mid
			assign prev_key = cell_key[i-1];
			assign prev_lt  = cell_lt[i-1];
		end

		if (i == N - 1) begin : g_last
			assign next_key = cell_key[i];
		end else begin : g_inner
			assign next_key = cell_key[i+1];
		end

		assign occupied = (skset_pkg::CNT_W'(i) < count_q);

		skset_cell u_cell (
			.clk       (clk),
			.cmp_en    (accept),
			.bcast_key (bcast_key),
			.occupied  (occupied),
			.ctrl      (ctrl),
			.prev_key  (prev_key),
			.prev_lt   (prev_lt),
			.next_key  (next_key),
			.key_out   (cell_key[i]),
			.lt_out    (cell_lt[i]),
			.eq_out    (cell_eq[i])
		);
	end

	skset_hit_tree u_hit_tree (
		.clk (clk),
		.eq  (cell_eq),
		.hit (hit)
	);

endmodule

`default_nettype wire
